// File: rtl/i2cms_pkg.sv
package i2cms_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_ADDR  = 3'd2,
    PH_DATA  = 3'd3,
    PH_LAST  = 3'd4,
    PH_STOP  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_SEND    = 3'd2,
    CMD_RX_ACK  = 3'd3,
    CMD_RX_NACK = 3'd4,
    CMD_STOP    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    E_OK      = 3'd0,
    E_NOTIDLE = 3'd1,
    E_START   = 3'd2,
    E_ADDR    = 3'd3,
    E_DATA    = 3'd4,
    E_STOPTO  = 3'd5
  } err_t;

  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_EVENT = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] K_WRITE = 2'd0;
  localparam logic [1:0] K_READ  = 2'd1;
  localparam logic [1:0] K_PROBE = 2'd2;
  localparam logic [1:0] K_ALIAS = 2'd3;

  localparam logic [7:0] ST_IDLE      = 8'hF8;
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_ADDR_W    = 8'h18;
  localparam logic [7:0] ST_DATA_W    = 8'h28;
  localparam logic [7:0] ST_ADDR_R    = 8'h40;
  localparam logic [7:0] ST_DATA_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_NACK = 8'h58;
  localparam logic [7:0] READ_BIT     = 8'h01;

  localparam logic [15:0] TIMEOUT_RESET = 16'hFFFF;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] kind;
    logic [7:0] address;
    logic [7:0] length;
    logic [7:0] status;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       success;
    logic [2:0] error_code;
  } out_item_t;

endpackage

// File: rtl/i2cms_in_if.sv
interface i2cms_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [1:0] kind;
  logic [7:0] address;
  logic [7:0] length;
  logic [7:0] status;
  logic [7:0] data;

  modport source (output valid, op, kind, address, length, status, data, input ready);
  modport sink   (input valid, op, kind, address, length, status, data, output ready);
endinterface

// File: rtl/i2cms_out_if.sv
interface i2cms_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] tx_byte;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       done_res;
  logic       success;
  logic [2:0] error_code;

  modport source (output valid, command, tx_byte, rx_valid, rx_byte, done_res, success,
                  error_code, input ready);
  modport sink   (input valid, command, tx_byte, rx_valid, rx_byte, done_res, success,
                  error_code, output ready);
endinterface

// File: rtl/i2c_master_transaction_sequencer.sv
// a request is held in the input register, decoded by the core, and its result registered in the result register
// throughput: one request per cycle while the result is taken, set by the input register and result register pair
// a stalled result holds, and the input register still takes one more request
// reset (rst, synchronous): sequencer idle, no request or result held,
// timeout limit back to 65535
module i2c_master_transaction_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [15:0] wr_data,
  i2cms_in_if.sink    item,
  i2cms_out_if.source result
);
  import i2cms_pkg::*;

  in_item_t  in_item;
  in_item_t  held_item;
  out_item_t res;
  out_item_t out_item;
  logic      held_valid;
  logic      advance;

  assign in_item.op      = item.op;
  assign in_item.kind    = item.kind;
  assign in_item.address = item.address;
  assign in_item.length  = item.length;
  assign in_item.status  = item.status;
  assign in_item.data    = item.data;

  i2cms_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (item.valid),
    .in_ready   (item.ready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  i2cms_core u_core (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .fire    (advance),
    .item    (held_item),
    .res     (res)
  );

  i2cms_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .res        (res),
    .advance    (advance),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_item   (out_item)
  );

  assign result.command    = out_item.command;
  assign result.tx_byte    = out_item.tx_byte;
  assign result.rx_valid   = out_item.rx_valid;
  assign result.rx_byte    = out_item.rx_byte;
  assign result.done_res   = out_item.done_res;
  assign result.success    = out_item.success;
  assign result.error_code = out_item.error_code;

endmodule

// File: rtl/i2cms_in_reg.sv
module i2cms_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2cms_pkg::in_item_t in_item,
  input  logic                advance,
  output logic                held_valid,
  output i2cms_pkg::in_item_t held_item
);
  import i2cms_pkg::*;

  logic     valid;
  in_item_t item;

  // refill in the same cycle the held request moves on
  assign in_ready   = !valid || advance;
  assign held_valid = valid;
  assign held_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// File: rtl/i2cms_core.sv
module i2cms_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [15:0]          wr_data,
  input  logic                 fire,
  input  i2cms_pkg::in_item_t  item,
  output i2cms_pkg::out_item_t res
);
  import i2cms_pkg::*;

  logic [15:0] timeout_limit;
  phase_t      phase, phase_next;
  logic [1:0]  transfer_kind, transfer_kind_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [15:0] wait_count, wait_count_next;
  err_t        pending_error, pending_error_next;
  logic [7:0]  saved_address, saved_address_next;

  logic [16:0] wait_inc;
  logic [15:0] wait_sat;
  logic        expired;
  logic [7:0]  bytes_dec;
  logic [1:0]  kind_eff;
  err_t        fin_err;
  err_t        ph_err;

  always_comb begin
    wait_inc = {1'b0, wait_count} + 17'd1;
    wait_sat = wait_inc[16] ? 16'hFFFF : wait_inc[15:0];
    expired  = (wait_sat >= timeout_limit);
    bytes_dec = bytes_left - 8'd1;
    kind_eff = (item.kind == K_ALIAS) ? K_PROBE : item.kind;
    fin_err  = (pending_error != E_OK) ? pending_error : E_STOPTO;
    unique case (phase)
      PH_START: ph_err = E_START;
      PH_ADDR:  ph_err = E_ADDR;
      default:  ph_err = E_DATA;
    endcase
  end

  always_comb begin
    phase_next         = phase;
    transfer_kind_next = transfer_kind;
    bytes_left_next    = bytes_left;
    wait_count_next    = wait_count;
    pending_error_next = pending_error;
    saved_address_next = saved_address;
    res                = '0;

    if (item.op == OP_BEGIN) begin
      if (phase == PH_IDLE) begin
        if (item.status != ST_IDLE) begin
          res.done_res       = 1'b1;
          res.error_code     = E_NOTIDLE;
          pending_error_next = E_OK;
          wait_count_next    = '0;
        end else begin
          transfer_kind_next = kind_eff;
          if (kind_eff == K_PROBE) begin
            bytes_left_next    = 8'd1;
            saved_address_next = item.address | READ_BIT;
          end else begin
            bytes_left_next    = (kind_eff == K_READ && item.length == 8'd0) ? 8'd1
                                                                             : item.length;
            saved_address_next = item.address;
          end
          pending_error_next = E_OK;
          res.command        = CMD_START;
          phase_next         = PH_START;
          wait_count_next    = '0;
        end
      end
    end else if (item.op == OP_EVENT || item.op == OP_TICK) begin
      if (phase == PH_STOP) begin
        if (item.status == ST_IDLE) begin
          res.done_res       = 1'b1;
          res.success        = (pending_error == E_OK);
          res.error_code     = pending_error;
          phase_next         = PH_IDLE;
          pending_error_next = E_OK;
          wait_count_next    = '0;
        end else if (item.op == OP_TICK) begin
          if (expired) begin
            res.done_res       = 1'b1;
            res.error_code     = fin_err;
            phase_next         = PH_IDLE;
            pending_error_next = E_OK;
            wait_count_next    = '0;
          end else begin
            wait_count_next = wait_sat;
          end
        end
      end else if (phase != PH_IDLE) begin
        if (item.op == OP_TICK) begin
          if (expired) begin
            pending_error_next = ph_err;
            res.command        = CMD_STOP;
            phase_next         = PH_STOP;
            wait_count_next    = '0;
          end else begin
            wait_count_next = wait_sat;
          end
        end else begin
          // every phase branch below issues a command, which clears the wait count; the default branch keeps it
          wait_count_next = '0;
          unique case (phase)
            PH_START: begin
              if (item.status != ST_START) begin
                pending_error_next = E_START;
                res.command        = CMD_STOP;
                phase_next         = PH_STOP;
              end else begin
                res.tx_byte = saved_address;
                res.command = CMD_SEND;
                phase_next  = PH_ADDR;
              end
            end
            PH_ADDR, PH_DATA: begin
              if (transfer_kind == K_WRITE) begin
                if (item.status != ((phase == PH_ADDR) ? ST_ADDR_W : ST_DATA_W)) begin
                  pending_error_next = ph_err;
                  res.command        = CMD_STOP;
                  phase_next         = PH_STOP;
                end else if (bytes_left == 8'd0) begin
                  pending_error_next = E_OK;
                  res.command        = CMD_STOP;
                  phase_next         = PH_STOP;
                end else begin
                  res.tx_byte     = item.data;
                  bytes_left_next = bytes_dec;
                  res.command     = CMD_SEND;
                  phase_next      = PH_DATA;
                end
              end else if (phase == PH_ADDR) begin
                if (item.status != ST_ADDR_R) begin
                  pending_error_next = E_ADDR;
                  res.command        = CMD_STOP;
                  phase_next         = PH_STOP;
                end else if (transfer_kind == K_READ && bytes_left > 8'd1) begin
                  res.command = CMD_RX_ACK;
                  phase_next  = PH_DATA;
                end else begin
                  res.command = CMD_RX_NACK;
                  phase_next  = PH_LAST;
                end
              end else begin
                if (item.status != ST_DATA_ACK) begin
                  pending_error_next = E_DATA;
                  res.command        = CMD_STOP;
                  phase_next         = PH_STOP;
                end else begin
                  res.rx_valid    = 1'b1;
                  res.rx_byte     = item.data;
                  bytes_left_next = bytes_dec;
                  if (bytes_dec > 8'd1) begin
                    res.command = CMD_RX_ACK;
                    phase_next  = PH_DATA;
                  end else begin
                    res.command = CMD_RX_NACK;
                    phase_next  = PH_LAST;
                  end
                end
              end
            end
            PH_LAST: begin
              if (item.status != ST_DATA_NACK) begin
                pending_error_next = E_DATA;
              end else begin
                // a probe byte is discarded
                if (transfer_kind == K_READ) begin
                  res.rx_valid = 1'b1;
                  res.rx_byte  = item.data;
                end
                bytes_left_next    = 8'd0;
                pending_error_next = E_OK;
              end
              res.command = CMD_STOP;
              phase_next  = PH_STOP;
            end
            default: begin
              wait_count_next = wait_count;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_RESET;
    end else if (wr_en) begin
      timeout_limit <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      transfer_kind <= K_WRITE;
      bytes_left    <= '0;
      wait_count    <= '0;
      pending_error <= E_OK;
      saved_address <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      transfer_kind <= transfer_kind_next;
      bytes_left    <= bytes_left_next;
      wait_count    <= wait_count_next;
      pending_error <= pending_error_next;
      saved_address <= saved_address_next;
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> pending_error == E_OK)
    else $error("error pending while idle");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    fire && res.done_res |=> phase == PH_IDLE)
    else $error("transaction finished but sequencer not idle");

  a_rx_only_read: assert property (@(posedge clk) disable iff (rst)
    fire && res.rx_valid |-> transfer_kind == K_READ)
    else $error("received byte reported outside a read");

  a_read_data_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA && transfer_kind == K_READ |-> bytes_left > 8'd1)
    else $error("read data phase with too few bytes left");

endmodule

// File: rtl/i2cms_out_reg.sv
module i2cms_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 held_valid,
  input  i2cms_pkg::out_item_t res,
  output logic                 advance,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cms_pkg::out_item_t out_item
);
  import i2cms_pkg::*;

  logic      valid;
  out_item_t item;
  logic      load_ok;

  assign load_ok   = !valid || out_ready;
  assign advance   = held_valid && load_ok;
  assign out_valid = valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_ok) begin
      valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item <= res;
    end
  end

endmodule
